// ===== sv/cbt_pkg.sv =====
package cbt_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned PARAM_W    = 17;
  localparam int unsigned WEIGHT_W   = 49;
  localparam int unsigned SQ_W       = 33;
  localparam int unsigned PROD_W     = SQ_W + PARAM_W;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = 13;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned ACC_W      = 40;

  localparam logic [PARAM_W-1:0]  ONE_Q16   = 17'h10000;
  localparam logic [PARAM_W-1:0]  STEP_MIN  = 17'h00001;
  localparam logic [WEIGHT_W-1:0] ONE_Q48   = 49'h1_0000_0000_0000;
  localparam logic [CNT_W-1:0]    LAST_DIG  = CNT_W'(NUM_DIGITS - 1);

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } cbt_state_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_UU,
    BS_VV,
    BS_W0,
    BS_W1,
    BS_W3,
    BS_W2,
    BS_SHIFT
  } cbt_bstate_e;

  // one weight digit of each basis term, least significant first
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic [DIGIT_W-1:0] d0;
    logic [DIGIT_W-1:0] d1;
    logic [DIGIT_W-1:0] d2;
    logic [DIGIT_W-1:0] d3;
  } cbt_dig_t;

endpackage

// ===== sv/cbt_req_if.sv =====
interface cbt_req_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] p0_x;
  logic signed [31:0] p0_y;
  logic signed [31:0] p1_x;
  logic signed [31:0] p1_y;
  logic signed [31:0] p2_x;
  logic signed [31:0] p2_y;
  logic signed [31:0] p3_x;
  logic signed [31:0] p3_y;
  logic [16:0]        step;

  modport source (
    output valid, func, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, step,
    input  ready
  );
  modport sink (
    input  valid, func, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, step,
    output ready
  );
endinterface

// ===== sv/cbt_rsp_if.sv =====
interface cbt_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [16:0]        param_value;
  logic               last_point;
  logic               point_valid;

  modport source (
    output valid, point_x, point_y, param_value, last_point, point_valid,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, param_value, last_point, point_valid,
    output ready
  );
endinterface

// ===== sv/cbt_basis.sv =====
module cbt_basis import cbt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [PARAM_W-1:0] u_i,
  output cbt_dig_t           dig_o
);

  cbt_bstate_e st_q, st_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [PARAM_W-1:0]  u_q, v_q;
  logic [SQ_W-1:0]     uu_q, vv_q;
  logic [PROD_W-1:0]   prod_q;
  logic [WEIGHT_W-1:0] w0_q, w1_q, w2_q, w3_q, rem_q;
  logic [SQ_W-1:0]     mul_a;
  logic [PARAM_W-1:0]  mul_b;
  logic [WEIGHT_W-1:0] prod_w, prod3;

  assign prod_w = WEIGHT_W'(prod_q);
  assign prod3  = prod_w + (prod_w << 1);

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BS_IDLE:  if (start_i) st_d = BS_UU;
      BS_UU:    st_d = BS_VV;
      BS_VV:    st_d = BS_W0;
      BS_W0:    st_d = BS_W1;
      BS_W1:    st_d = BS_W3;
      BS_W3:    st_d = BS_W2;
      BS_W2:    st_d = BS_SHIFT;
      BS_SHIFT: if (cnt_q == LAST_DIG) st_d = BS_IDLE;
      default:  st_d = BS_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    cnt_d = cnt_q;
    unique case (st_q)
      BS_UU: begin
        mul_a = SQ_W'(u_q);
        mul_b = u_q;
      end
      BS_VV: begin
        mul_a = SQ_W'(v_q);
        mul_b = v_q;
      end
      BS_W0: begin
        mul_a = uu_q;
        mul_b = u_q;
      end
      BS_W1: begin
        mul_a = uu_q;
        mul_b = v_q;
      end
      BS_W3: begin
        mul_a = vv_q;
        mul_b = v_q;
      end
      BS_W2:    cnt_d = '0;
      BS_SHIFT: cnt_d = cnt_q + 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= BS_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (st_q == BS_IDLE && start_i) begin
      u_q <= u_i;
      v_q <= ONE_Q16 - u_i;
    end
    unique case (st_q)
      BS_VV: uu_q <= SQ_W'(prod_q);
      BS_W0: vv_q <= SQ_W'(prod_q);
      BS_W1: begin
        w0_q  <= prod_w;
        rem_q <= ONE_Q48 - prod_w;
      end
      BS_W3: begin
        w1_q  <= prod3;
        rem_q <= rem_q - prod3;
      end
      BS_W2: begin
        w3_q <= prod_w;
        w2_q <= rem_q - prod_w;
      end
      BS_SHIFT: begin
        w0_q <= w0_q >> DIGIT_W;
        w1_q <= w1_q >> DIGIT_W;
        w2_q <= w2_q >> DIGIT_W;
        w3_q <= w3_q >> DIGIT_W;
      end
      default: ;
    endcase
  end

  always_comb begin
    dig_o.valid = (st_q == BS_SHIFT);
    dig_o.first = (cnt_q == '0);
    dig_o.last  = (cnt_q == LAST_DIG);
    dig_o.d0    = w0_q[DIGIT_W-1:0];
    dig_o.d1    = w1_q[DIGIT_W-1:0];
    dig_o.d2    = w2_q[DIGIT_W-1:0];
    dig_o.d3    = w3_q[DIGIT_W-1:0];
  end

endmodule

// ===== sv/cbt_blend.sv =====
module cbt_blend import cbt_pkg::*; (
  input  logic                      clk_i,
  input  cbt_dig_t                  dig_i,
  input  logic signed [COORD_W-1:0] p0_i,
  input  logic signed [COORD_W-1:0] p1_i,
  input  logic signed [COORD_W-1:0] p2_i,
  input  logic signed [COORD_W-1:0] p3_i,
  output logic signed [COORD_W-1:0] point_o
);

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sd2147483648);

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [ACC_W-1:0] c0, c1, c2, c3, base, sum;

  // acc keeps floor(partial sum / 16^k); the top digit is bit 48 alone, no shift
  assign c0   = ACC_W'(p0_i) * ACC_W'($signed({1'b0, dig_i.d0}));
  assign c1   = ACC_W'(p1_i) * ACC_W'($signed({1'b0, dig_i.d1}));
  assign c2   = ACC_W'(p2_i) * ACC_W'($signed({1'b0, dig_i.d2}));
  assign c3   = ACC_W'(p3_i) * ACC_W'($signed({1'b0, dig_i.d3}));
  assign base = dig_i.first ? '0 : acc_q;
  assign sum  = base + c0 + c1 + c2 + c3;

  always_comb begin
    acc_d = acc_q;
    if (dig_i.valid) begin
      acc_d = dig_i.last ? sum : (sum >>> DIGIT_W);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  always_comb begin
    priority if (acc_q > SAT_MAX) begin
      point_o = SAT_MAX[COORD_W-1:0];
    end else if (acc_q < SAT_MIN) begin
      point_o = SAT_MIN[COORD_W-1:0];
    end else begin
      point_o = acc_q[COORD_W-1:0];
    end
  end

endmodule

// ===== sv/cubic_bezier_tessellator.sv =====
// Operation: an accepted start or advance runs the basis products on one shared
// 33x17 multiplier, feeds 13 four-bit weight digits into the accumulators and,
// once the output register is free, loads its result there; an advance with no
// active segment skips the calculation. A new request is taken only after that
// result is handed off and control returns to idle.
// Reset: asynchronous, active low; clears control state, segment goes idle.
module cubic_bezier_tessellator import cbt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cbt_req_if.sink    req_i,
  cbt_rsp_if.source  rsp_o
);

  cbt_state_e st_q, st_d;
  logic                      active_q, active_d;
  logic                      ok_q, ok_d;
  logic [PARAM_W-1:0]        u_q, u_d;
  logic [PARAM_W-1:0]        step_q;
  logic [PARAM_W-1:0]        step_in;
  logic signed [COORD_W-1:0] p0x_q, p0y_q, p1x_q, p1y_q, p2x_q, p2y_q, p3x_q, p3y_q;
  logic                      out_valid_q, out_valid_d;
  logic signed [COORD_W-1:0] out_x_q, out_y_q;
  logic [PARAM_W-1:0]        out_u_q;
  logic                      out_last_q, out_ok_q;
  logic signed [COORD_W-1:0] blend_x, blend_y;
  logic [PARAM_W-1:0]        u_start;
  cbt_dig_t                  dig;
  logic                      accept, is_start, run, commit, out_free, seg_end;

  assign accept   = req_i.valid && req_i.ready;
  assign is_start = (req_i.func == FUNC_START);
  assign run      = is_start || active_q;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign u_start  = is_start ? ONE_Q16 : u_q;
  assign seg_end  = (step_q > u_q);

  always_comb begin
    priority if (req_i.step == '0) begin
      step_in = STEP_MIN;
    end else if (req_i.step > ONE_Q16) begin
      step_in = ONE_Q16;
    end else begin
      step_in = req_i.step;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE: if (accept) st_d = run ? ST_CALC : ST_DONE;
      ST_CALC: if (dig.valid && dig.last) st_d = ST_DONE;
      ST_DONE: if (out_free) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_i.ready = (st_q == ST_IDLE);
    commit      = (st_q == ST_DONE) && out_free;
  end

  always_comb begin
    active_d = active_q;
    u_d      = u_q;
    ok_d     = ok_q;
    if (accept) begin
      ok_d = run;
      if (is_start) begin
        active_d = 1'b1;
        u_d      = ONE_Q16;
      end
    end else if (commit && ok_q) begin
      if (seg_end) begin
        active_d = 1'b0;
        u_d      = '0;
      end else begin
        u_d = u_q - step_q;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      active_q    <= 1'b0;
      ok_q        <= 1'b0;
      u_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      active_q    <= active_d;
      ok_q        <= ok_d;
      u_q         <= u_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_start) begin
      p0x_q  <= req_i.p0_x;
      p0y_q  <= req_i.p0_y;
      p1x_q  <= req_i.p1_x;
      p1y_q  <= req_i.p1_y;
      p2x_q  <= req_i.p2_x;
      p2y_q  <= req_i.p2_y;
      p3x_q  <= req_i.p3_x;
      p3y_q  <= req_i.p3_y;
      step_q <= step_in;
    end
    if (commit) begin
      out_x_q    <= ok_q ? blend_x : '0;
      out_y_q    <= ok_q ? blend_y : '0;
      out_u_q    <= ok_q ? u_q : '0;
      out_last_q <= ok_q && seg_end;
      out_ok_q   <= ok_q;
    end
  end

  cbt_basis u_basis (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept && run),
    .u_i     (u_start),
    .dig_o   (dig)
  );

  cbt_blend u_blend_x (
    .clk_i   (clk_i),
    .dig_i   (dig),
    .p0_i    (p0x_q),
    .p1_i    (p1x_q),
    .p2_i    (p2x_q),
    .p3_i    (p3x_q),
    .point_o (blend_x)
  );

  cbt_blend u_blend_y (
    .clk_i   (clk_i),
    .dig_i   (dig),
    .p0_i    (p0y_q),
    .p1_i    (p1y_q),
    .p2_i    (p2y_q),
    .p3_i    (p3y_q),
    .point_o (blend_y)
  );

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.point_x     = out_x_q;
  assign rsp_o.point_y     = out_y_q;
  assign rsp_o.param_value = out_u_q;
  assign rsp_o.last_point  = out_last_q;
  assign rsp_o.point_valid = out_ok_q;

endmodule
